/* hdl/oaht_pkg.sv */
// Shared types and constants for the open-addressing hash table.
// Used by oaht_store, oaht_ctrl and the top level; depends on nothing.
package oaht_pkg;

    // Default sizing handed down from the top level
    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 64;

    // Fixed field widths
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int LIMIT_W  = 8;
    localparam int USED_W   = 9;
    localparam int PORT_VAL_W = 64;

    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 8'd192;

    // Request codes
    localparam logic [1:0] REQ_GET = 2'd0;
    localparam logic [1:0] REQ_SET = 2'd1;
    localparam logic [1:0] REQ_DEL = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NULL = 2'd3;

    // Slot store access controls
    typedef struct packed {
        logic rd;    // read key, tombstone and value at the address
        logic wr;    // write key, tombstone and value at the address
        logic tomb;  // tombstone bit to write
    } t_mem_ctl;

endpackage

/* hdl/oaht_store.sv */
// Slot store: key/tombstone memory and value memory sharing one address.
// Depends on oaht_pkg for t_mem_ctl and KEY_W.
module oaht_store import oaht_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int ADDR_W    = $clog2(CAPACITY)
) (
    input  logic                  i_clk,
    input  t_mem_ctl              i_ctl,
    input  logic [ADDR_W-1:0]     i_addr,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [VALUE_BITS-1:0] i_val,
    output logic [KEY_W-1:0]      o_key,
    output logic                  o_tomb,
    output logic [VALUE_BITS-1:0] o_val
);

    logic [KEY_W:0]        r_kt_mem  [CAPACITY];
    logic [VALUE_BITS-1:0] r_val_mem [CAPACITY];
    logic [KEY_W:0]        r_kt_rd;
    logic [VALUE_BITS-1:0] r_val_rd;

    // Write slot entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_kt_mem[i_addr]  <= {i_ctl.tomb, i_key};
            r_val_mem[i_addr] <= i_val;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_kt_rd  <= r_kt_mem[i_addr];
            r_val_rd <= r_val_mem[i_addr];
        end
    end

    assign o_key  = r_kt_rd[KEY_W-1:0];
    assign o_tomb = r_kt_rd[KEY_W];
    assign o_val  = r_val_rd;

endmodule

/* hdl/oaht_ctrl.sv */
// Probe sequencer: home-slot reduction, slot-by-slot probe, update and result register.
// Depends on oaht_pkg for codes and t_mem_ctl; drives oaht_store.
module oaht_ctrl import oaht_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int ADDR_W    = $clog2(CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_req,
    input  logic [KEY_W-1:0]      i_key,
    input  logic [HASH_W-1:0]     i_hash,
    input  logic [VALUE_BITS-1:0] i_val,
    input  logic [LIMIT_W-1:0]    i_load_limit,
    // slot store
    output t_mem_ctl              o_mem,
    output logic [ADDR_W-1:0]     o_addr,
    output logic [KEY_W-1:0]      o_wkey,
    output logic [VALUE_BITS-1:0] o_wval,
    input  logic [KEY_W-1:0]      i_rkey,
    input  logic                  i_rtomb,
    input  logic [VALUE_BITS-1:0] i_rval,
    // result
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic                  o_is_new,
    output logic [VALUE_BITS-1:0] o_vout
);

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CAPACITY - 1);
    localparam bit                IS_POW2  = ((CAPACITY & (CAPACITY - 1)) == 0);
    // floor(2^32 / CAPACITY): the quotient estimate is at most one short
    localparam logic [HASH_W-1:0] RECIP    = HASH_W'((64'd1 << HASH_W) / 64'(CAPACITY));
    localparam logic [HASH_W-1:0] CAP_H    = HASH_W'(CAPACITY);
    localparam logic [1:0]        STEP_LAST = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_WRITE, S_DONE
    } t_state;

    t_state                r_state;
    logic [1:0]            r_req;
    logic [KEY_W-1:0]      r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [HASH_W-1:0]     r_div;
    logic [2*HASH_W-1:0]   r_prod;
    logic [1:0]            r_step;
    logic [ADDR_W-1:0]     r_idx;
    logic [ADDR_W-1:0]     r_cnt;
    logic                  r_has_tomb;
    logic [ADDR_W-1:0]     r_tomb;
    logic [USED_W-1:0]     r_used;
    logic [ADDR_W-1:0]     r_wr_addr;
    logic [KEY_W-1:0]      r_wr_key;
    logic                  r_wr_tomb;
    logic [VALUE_BITS-1:0] r_wr_val;
    logic [1:0]            r_status;
    logic                  r_is_new;
    logic [VALUE_BITS-1:0] r_vout;
    logic                  r_out_valid;
    logic [1:0]            r_o_status;
    logic                  r_o_is_new;
    logic [VALUE_BITS-1:0] r_o_vout;

    logic [HASH_W-1:0]     c_mul_a;
    logic [HASH_W-1:0]     c_mul_b;
    logic [2*HASH_W-1:0]   c_mul;
    logic [HASH_W-1:0]     c_rem_raw;
    logic [HASH_W-1:0]     c_rem_fix;
    logic                  c_cur_gap;
    logic                  c_cur_tomb;
    logic                  c_cur_hit;
    logic                  c_last;
    logic                  c_stop;
    logic                  c_tomb_any;
    logic [ADDR_W-1:0]     c_tomb_at;
    logic [ADDR_W-1:0]     c_idx_next;
    logic                  c_room;

    // Shared multiplier for hash mod CAPACITY: hash times reciprocal, then
    // quotient estimate times CAPACITY; one compare and subtract finishes it
    always_comb begin
        c_mul_a   = (r_step == 2'd0) ? r_div : r_prod[2*HASH_W-1:HASH_W];
        c_mul_b   = (r_step == 2'd0) ? RECIP : CAP_H;
        c_mul     = {{HASH_W{1'b0}}, c_mul_a} * {{HASH_W{1'b0}}, c_mul_b};
        c_rem_raw = r_div - r_prod[HASH_W-1:0];
        c_rem_fix = (c_rem_raw >= CAP_H) ? (c_rem_raw - CAP_H) : c_rem_raw;
    end

    // Classify the slot just read
    always_comb begin
        c_cur_gap  = (i_rkey == '0) && !i_rtomb;
        c_cur_tomb = (i_rkey == '0) && i_rtomb;
        c_cur_hit  = (i_rkey == r_key);
        c_last     = (r_cnt == LAST_IDX);
        c_stop     = c_cur_gap || c_cur_hit || c_last;
        c_tomb_any = r_has_tomb || c_cur_tomb;
        c_tomb_at  = r_has_tomb ? r_tomb : r_idx;
        c_idx_next = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        c_room     = ({1'b0, r_used} + 10'd1) <= {2'b00, i_load_limit};
    end

    // Drive the slot store
    always_comb begin
        o_mem  = '0;
        o_addr = r_idx;
        o_wkey = '0;
        o_wval = '0;
        case (r_state)
            S_CLEAR: begin
                o_mem.wr = 1'b1;
            end
            S_READ: begin
                o_mem.rd = 1'b1;
            end
            S_WRITE: begin
                o_mem.wr   = 1'b1;
                o_mem.tomb = r_wr_tomb;
                o_addr     = r_wr_addr;
                o_wkey     = r_wr_key;
                o_wval     = r_wr_val;
            end
            default: begin
                o_mem = '0;
            end
        endcase
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                // sweep every slot to empty after reset
                S_CLEAR: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_req      <= i_req;
                        r_key      <= i_key;
                        r_val      <= i_val;
                        r_div      <= i_hash;
                        r_step     <= '0;
                        r_idx      <= i_hash[ADDR_W-1:0];
                        r_cnt      <= '0;
                        r_has_tomb <= 1'b0;
                        r_is_new   <= 1'b0;
                        r_vout     <= '0;
                        if (i_key == '0) begin
                            r_status <= ST_NULL;
                            r_state  <= S_DONE;
                        end else if (i_req != REQ_GET && i_req != REQ_SET
                                     && i_req != REQ_DEL) begin
                            r_status <= ST_MISS;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= IS_POW2 ? S_READ : S_HASH;
                        end
                    end
                end
                // reduce the hash in three steps: two on the shared multiplier, then a compare and subtract
                S_HASH: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_idx   <= ADDR_W'(c_rem_fix);
                        r_state <= S_READ;
                    end else begin
                        r_prod <= c_mul;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (!c_stop) begin
                        // advance to the next slot
                        if (c_cur_tomb && !r_has_tomb) begin
                            r_has_tomb <= 1'b1;
                            r_tomb     <= r_idx;
                        end
                        r_idx   <= c_idx_next;
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_READ;
                    end else begin
                        case (r_req)
                            REQ_GET: begin
                                r_state <= S_DONE;
                                if (c_cur_hit) begin
                                    r_vout <= i_rval;
                                end else begin
                                    r_status <= ST_MISS;
                                end
                            end
                            REQ_SET: begin
                                r_wr_key  <= r_key;
                                r_wr_tomb <= 1'b0;
                                r_wr_val  <= r_val;
                                if (c_cur_hit) begin
                                    r_wr_addr <= r_idx;
                                    r_state   <= S_WRITE;
                                end else if (c_tomb_any) begin
                                    r_wr_addr <= c_tomb_at;
                                    r_is_new  <= 1'b1;
                                    r_state   <= S_WRITE;
                                end else if (c_cur_gap && c_room) begin
                                    r_wr_addr <= r_idx;
                                    r_is_new  <= 1'b1;
                                    r_used    <= r_used + 1'b1;
                                    r_state   <= S_WRITE;
                                end else begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end
                            end
                            REQ_DEL: begin
                                r_wr_key  <= '0;
                                r_wr_tomb <= 1'b1;
                                r_wr_val  <= '0;
                                r_wr_addr <= r_idx;
                                if (c_cur_hit) begin
                                    r_state <= S_WRITE;
                                end else begin
                                    r_status <= ST_MISS;
                                    r_state  <= S_DONE;
                                end
                            end
                            default: begin
                                r_status <= ST_MISS;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                // hand the result over once the output register is free
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_is_new  <= r_is_new;
                        r_o_vout    <= r_vout;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_is_new    = r_o_is_new;
    assign o_vout      = r_o_vout;

endmodule

/* hdl/open_addressing_hash_table.sv */
// Open-addressing hash table top level: stream ports, load-limit register, assertions.
// Depends on oaht_pkg, oaht_store and oaht_ctrl.
//
// Keyed table of CAPACITY slots with linear probing and tombstones. Each request beat
// (get, set or delete) returns exactly one result beat. After reset the block sweeps
// every slot to empty, one slot a cycle, and accepts no request until the sweep
// is done; the load-limit register can be written at any time. A request is taken,
// then each slot probed is read and compared in turn through the single-ported slot
// store, a slot is written when the request changes one, and the result is handed
// over once the output register is free. When CAPACITY is not a power of two the
// home slot is found by a reciprocal multiplication on one shared multiplier
// followed by a compare and subtract. Null-key and unknown requests skip the
// probe. One request is in flight at a time; a new one is taken while the
// previous result still waits on the master side.
module open_addressing_hash_table import oaht_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int ADDR_W    = $clog2(CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [127:0]          i_s_tdata,   // key_id[31:0], key_hash[63:32], value_in[127:64]
    input  logic [1:0]            i_s_tuser,   // req_type[1:0]
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [63:0]           o_m_tdata,   // value_out[63:0]
    output logic [2:0]            o_m_tuser,   // status[1:0], is_new[2]
    // load-limit write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [LIMIT_W-1:0]    i_cfg_data
);

    logic [LIMIT_W-1:0]    r_load_limit;
    t_mem_ctl              w_mem;
    logic [ADDR_W-1:0]     w_addr;
    logic [KEY_W-1:0]      w_wkey;
    logic [VALUE_BITS-1:0] w_wval;
    logic [KEY_W-1:0]      w_rkey;
    logic                  w_rtomb;
    logic [VALUE_BITS-1:0] w_rval;
    logic [1:0]            w_status;
    logic                  w_is_new;
    logic [VALUE_BITS-1:0] w_vout;

    // Hold the load limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_limit <= LOAD_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_load_limit <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    oaht_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_req        (i_s_tuser),
        .i_key        (i_s_tdata[31:0]),
        .i_hash       (i_s_tdata[63:32]),
        .i_val        (i_s_tdata[64 +: VALUE_BITS]),
        .i_load_limit (r_load_limit),
        .o_mem        (w_mem),
        .o_addr       (w_addr),
        .o_wkey       (w_wkey),
        .o_wval       (w_wval),
        .i_rkey       (w_rkey),
        .i_rtomb      (w_rtomb),
        .i_rval       (w_rval),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_status     (w_status),
        .o_is_new     (w_is_new),
        .o_vout       (w_vout)
    );

    oaht_store #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk  (i_clk),
        .i_ctl  (w_mem),
        .i_addr (w_addr),
        .i_key  (w_wkey),
        .i_val  (w_wval),
        .o_key  (w_rkey),
        .o_tomb (w_rtomb),
        .o_val  (w_rval)
    );

    // Pack the result beat
    assign o_m_tdata = PORT_VAL_W'(w_vout);
    assign o_m_tuser = {w_is_new, w_status};

    // No request is taken in the cycle after reset: the clearing sweep runs first
    a_no_accept_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_s_tready)
        else $error("request accepted during clearing sweep");

    // A new key is only reported on a completed request
    a_new_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> (o_m_tuser[1:0] == ST_OK))
        else $error("is_new set on a refused or missed request");

    // A non-zero value only comes back from a successful get
    a_value_only_on_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata != '0)) |-> ((o_m_tuser[1:0] == ST_OK) && !o_m_tuser[2]))
        else $error("value returned outside a successful get");

    // The block never takes a new request while the previous one is still in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second request taken while one is in flight");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for open_addressing_hash_table: stream requests in, results out.
// Depends on oaht_pkg and the RTL under hdl; holds its own table predictor and result queue.
module tb_top;
    import oaht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = CAPACITY_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [1:0] REQ_BAD = 2'd3;  // not a valid request code

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [31:0] hash;
        logic [63:0] val;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_new;
        logic [63:0] value;
    } t_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [127:0]       i_s_tdata = '0;   // key_id[31:0], key_hash[63:32], value_in[127:64]
    logic [1:0]         i_s_tuser = '0;   // req_type[1:0]
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [63:0]        o_m_tdata;        // value_out[63:0]
    logic [2:0]         o_m_tuser;        // status[1:0], is_new[2]
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [LIMIT_W-1:0] i_cfg_data = '0;

    // Predicted table contents
    logic [31:0]        tbl_key [SLOTS];
    logic [63:0]        tbl_val [SLOTS];
    bit                 tbl_tomb [SLOTS];
    int unsigned        tbl_used;
    logic [LIMIT_W-1:0] tbl_limit;

    t_answer     answers_due[$];
    logic [31:0] pool_key[$];
    logic [31:0] pool_hash[$];

    int mismatches;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_reqs;
    int hold_seen;
    int hold_left;
    int quiet_cycles;

    open_addressing_hash_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the predicted table and return the answer it owes
    function automatic t_answer table_apply(t_req r);
        t_answer a;
        int idx;
        bit hit, gap, tomb_seen;
        int hit_at, gap_at, tomb_at;
        a = '0;
        hit = 0;
        gap = 0;
        tomb_seen = 0;
        hit_at = 0;
        gap_at = 0;
        tomb_at = 0;
        idx = int'(r.hash % SLOTS);
        // walk the chain until the key or a never-used slot turns up
        for (int n = 0; n < SLOTS; n++) begin
            if (tbl_key[idx] == '0) begin
                if (!tbl_tomb[idx]) begin
                    gap = 1;
                    gap_at = idx;
                    break;
                end
                if (!tomb_seen) begin
                    tomb_seen = 1;
                    tomb_at = idx;
                end
            end else if (tbl_key[idx] == r.key) begin
                hit = 1;
                hit_at = idx;
                break;
            end
            idx = (idx + 1) % SLOTS;
        end
        if (r.key == '0) begin
            a.status = ST_NULL;
        end else begin
            case (r.kind)
                REQ_GET: begin
                    if (hit) a.value = tbl_val[hit_at];
                    else a.status = ST_MISS;
                end
                REQ_SET: begin
                    if (hit) begin
                        tbl_val[hit_at] = r.val;
                    end else if (tomb_seen) begin
                        tbl_key[tomb_at] = r.key;
                        tbl_val[tomb_at] = r.val;
                        tbl_tomb[tomb_at] = 0;
                        a.is_new = 1'b1;
                    end else if (gap && tbl_used + 1 <= tbl_limit) begin
                        tbl_key[gap_at] = r.key;
                        tbl_val[gap_at] = r.val;
                        tbl_used++;
                        a.is_new = 1'b1;
                    end else begin
                        a.status = ST_FULL;
                    end
                end
                REQ_DEL: begin
                    if (hit) begin
                        tbl_key[hit_at] = '0;
                        tbl_val[hit_at] = '0;
                        tbl_tomb[hit_at] = 1;
                    end else begin
                        a.status = ST_MISS;
                    end
                end
                default: a.status = ST_MISS;
            endcase
        end
        return a;
    endfunction

    // Offer one request beat, idling first at the current rate, and log its answer
    task automatic send_req(logic [1:0] kind, logic [31:0] key, logic [31:0] hash,
                            logic [63:0] val);
        t_req r;
        r = {kind, key, hash, val};
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {val, hash, key};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        answers_due.push_back(table_apply(r));
    endtask

    // Drop valid and hold until every owed answer has come back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] limit);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        tbl_limit = limit;
        i_cfg_valid <= 1'b0;
    endtask

    // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both
    task automatic set_idle(int mode);
        tx_idle_pct = (mode == 1) ? 55 : (mode == 3) ? 33 : 0;
        rx_stall_pct <= (mode == 2) ? 55 : (mode == 3) ? 33 : 0;
    endtask

    // Fresh key pool; home slots cluster in a window of span slots to force long chains
    task automatic build_pool(int count, int span);
        logic [31:0] h;
        logic [7:0]  base;
        pool_key.delete();
        pool_hash.delete();
        base = 8'($urandom);
        repeat (count) begin
            h = $urandom;
            h[7:0] = base + 8'($urandom_range(span - 1));
            pool_key.push_back($urandom | 32'd1);
            pool_hash.push_back(h);
        end
    endtask

    // Mostly pool traffic with consistent hashes; a little noise on top
    function automatic t_req pick_request();
        t_req r;
        int dice, k;
        dice = $urandom_range(99);
        k = $urandom_range(pool_key.size() - 1);
        r.key  = pool_key[k];
        r.hash = pool_hash[k];
        r.val  = {$urandom, $urandom};
        if (dice < 40) begin
            r.kind = REQ_GET;
        end else if (dice < 78) begin
            r.kind = REQ_SET;
        end else if (dice < 93) begin
            r.kind = REQ_DEL;
        end else if (dice < 95) begin
            r.kind = REQ_BAD;
        end else if (dice < 97) begin
            r.kind = 2'($urandom_range(3));
            r.key = '0;
        end else begin
            r.kind = 2'($urandom_range(2));
            r.key = $urandom;
            r.hash = $urandom;
        end
        return r;
    endfunction

    // Random traffic, rotating the idle mode every 25 beats
    task automatic run_random(int count);
        t_req r;
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) set_idle((i / 25) % 4);
            r = pick_request();
            send_req(r.kind, r.key, r.hash, r.val);
        end
        set_idle(0);
    endtask

    task automatic test_directed_ops();
        set_idle(0);
        // null key on every request code
        send_req(REQ_GET, 32'h0, 32'h1234_5678, 64'h0);
        send_req(REQ_SET, 32'h0, 32'hFFFF_FFFF, '1);
        send_req(REQ_DEL, 32'h0, 32'h0, 64'h0);
        send_req(REQ_BAD, 32'h0, 32'h0, 64'h0);
        // unknown request code
        send_req(REQ_BAD, 32'h5, 32'h5, '1);
        // two keys sharing the last home slot, the second wrapping to slot 0
        send_req(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
        send_req(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        send_req(REQ_SET, 32'h0000_0001, 32'h0000_00FF, 64'h0);
        send_req(REQ_GET, 32'h0000_0001, 32'h0000_00FF, '1);
        send_req(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
        // overwrite an existing key
        send_req(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
        send_req(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
        // delete, delete again, then probe across the tombstone
        send_req(REQ_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        send_req(REQ_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
        send_req(REQ_GET, 32'h0000_0001, 32'h0000_00FF, 64'h0);
        // new key takes the earliest tombstone
        send_req(REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF, 64'hA5A5_5A5A_F0F0_0F0F);
        send_req(REQ_GET, 32'h8000_0000, 32'h7FFF_FFFF, 64'h0);
        send_req(REQ_DEL, 32'h0000_0001, 32'h0000_00FF, 64'h0);
        send_req(REQ_SET, 32'h1234_5678, 32'h0000_0100, 64'hFEDC_BA98_7654_3210);
        // same home slot, different upper hash bits
        send_req(REQ_GET, 32'h1234_5678, 32'hFFFF_FF00, 64'h0);
        send_req(REQ_GET, 32'h5A5A_5A5A, 32'h0000_00FF, 64'h0);
    endtask

    task automatic test_load_limit_edge();
        write_limit(8'd1);
        // fresh slot refused, tombstone reuse still allowed
        send_req(REQ_SET, 32'h0BAD_CAFE, 32'h0000_0010, '1);
        send_req(REQ_DEL, 32'h8000_0000, 32'h7FFF_FFFF, 64'h0);
        send_req(REQ_SET, 32'h7FFF_FFFF, 32'h8000_00FF, 64'h5555_AAAA_5555_AAAA);
        send_req(REQ_GET, 32'h7FFF_FFFF, 32'h8000_00FF, 64'h0);
        build_pool(16, 4);
        run_random(150);
    endtask

    task automatic test_moderate_load();
        write_limit(8'd40);
        build_pool(48, 16);
        run_random(300);
    endtask

    task automatic test_backpressure();
        t_req r;
        set_idle(0);
        // receiver holds off while requests keep coming
        hold_reqs <= hold_reqs + 1;
        repeat (20) begin
            r = pick_request();
            send_req(r.kind, r.key, r.hash, r.val);
        end
        // sender pauses until every answer is back
        wait_drained();
        repeat (10) begin
            r = pick_request();
            send_req(r.kind, r.key, r.hash, r.val);
        end
    endtask

    task automatic test_heavy_fill();
        write_limit(8'd255);
        build_pool(320, 128);
        run_random(850);
    endtask

    task automatic test_limit_below_use();
        write_limit(8'd128);
        run_random(200);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen  <= hold_reqs;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check each result beat against the oldest owed answer
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (answers_due.size() == 0) begin
                $error("result beat with no request owing it");
                mismatches++;
            end else begin
                exp_a = answers_due.pop_front();
                if (o_m_tuser[1:0] !== exp_a.status) begin
                    $error("status: expected %0d, got %0d", exp_a.status, o_m_tuser[1:0]);
                    mismatches++;
                end
                if (o_m_tuser[2] !== exp_a.is_new) begin
                    $error("is_new: expected %0d, got %0d", exp_a.is_new, o_m_tuser[2]);
                    mismatches++;
                end
                if (o_m_tdata !== exp_a.value) begin
                    $error("value_out: expected %h, got %h", exp_a.value, o_m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        mismatches   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_reqs    = 0;
        hold_seen    = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_key[i]  = '0;
            tbl_val[i]  = '0;
            tbl_tomb[i] = 0;
        end
        tbl_used  = 0;
        tbl_limit = LOAD_LIMIT_RST;

        // hold reset low before releasing it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_load_limit_edge();
        test_moderate_load();
        test_backpressure();
        test_heavy_fill();
        test_limit_below_use();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
